[hw/rtl/keypad_debounce_autorepeat_macros.svh]
// Assertion macros shared by the keypad debounce RTL.
`ifndef KEYPAD_DEBOUNCE_AUTOREPEAT_MACROS_SVH
`define KEYPAD_DEBOUNCE_AUTOREPEAT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while in reset.
`define KDA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keypad debounce: assertion failed");
// Next-cycle implication, disabled while in reset.
`define KDA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keypad debounce: assertion failed");
`else
`define KDA_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define KDA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[hw/rtl/kda_pkg.sv]
package kda_pkg;

    // Input request: tick or poll with active-low pin samples
    typedef struct packed {
        logic       mode;
        logic [3:0] row_pins;
        logic [3:0] col_pins;
    } in_item_t;

    // Result: debounced code and press/repeat flag
    typedef struct packed {
        logic [7:0] key_code;
        logic       key_event;
    } out_item_t;

    // Configuration register set
    typedef struct packed {
        logic [7:0]  first_holdoff;
        logic [7:0]  second_holdoff;
        logic [15:0] initial_repeat_delay;
        logic [15:0] repeat_interval;
    } cfg_t;

    // Register indexes (byte address = 4 * index)
    typedef enum logic [1:0] {
        REG_FIRST_HOLDOFF   = 2'd0,
        REG_SECOND_HOLDOFF  = 2'd1,
        REG_INITIAL_DELAY   = 2'd2,
        REG_REPEAT_INTERVAL = 2'd3
    } reg_idx_t;

    // Request kinds
    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_POLL = 1'b1;

    // Register reset values
    localparam logic [7:0]  FIRST_HOLDOFF_RST   = 8'd10;
    localparam logic [7:0]  SECOND_HOLDOFF_RST  = 8'd5;
    localparam logic [15:0] INITIAL_DELAY_RST   = 16'd500;
    localparam logic [15:0] REPEAT_INTERVAL_RST = 16'd120;

    // Debounce stage, one-hot
    typedef enum logic [2:0] {
        STAGE_IDLE   = 3'b001,
        STAGE_FIRST  = 3'b010,
        STAGE_SECOND = 3'b100
    } scan_stage_t;

endpackage

[hw/rtl/kda_core.sv]
module kda_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  kda_pkg::in_item_t item,
    input  kda_pkg::cfg_t     cfg,
    output kda_pkg::out_item_t result
);

`include "keypad_debounce_autorepeat_macros.svh"

    kda_pkg::scan_stage_t stage_reg, stage_next;
    logic [7:0]  prev_scan_reg, prev_scan_next;
    logic [7:0]  last_code_reg, last_code_next;
    logic [7:0]  holdoff_reg, holdoff_next;
    logic [15:0] repeat_reg, repeat_next;

    logic [7:0] scan;
    logic [7:0] code;
    logic       key_event;

    // Active-low pins: rows form the upper nibble
    assign scan = {~item.row_pins, ~item.col_pins};

    // Debounce and event generation for one request
    always_comb
    begin
        stage_next     = stage_reg;
        prev_scan_next = prev_scan_reg;
        last_code_next = last_code_reg;
        holdoff_next   = holdoff_reg;
        repeat_next    = repeat_reg;
        code           = 8'd0;
        key_event      = 1'b0;

        if (item.mode == kda_pkg::MODE_TICK)
        begin
            // Timers count down and stop at zero
            if (holdoff_reg != 8'd0)
                holdoff_next = holdoff_reg - 8'd1;
            if (repeat_reg != 16'd0)
                repeat_next = repeat_reg - 16'd1;
        end
        else
        begin
            // Three-stage debounce, gated by hold-off
            priority if (holdoff_reg != 8'd0)
            begin
                code = 8'd0;
            end
            else if (scan != prev_scan_reg)
            begin
                stage_next     = kda_pkg::STAGE_FIRST;
                holdoff_next   = cfg.first_holdoff;
                prev_scan_next = scan;
            end
            else if (stage_reg == kda_pkg::STAGE_FIRST)
            begin
                stage_next   = kda_pkg::STAGE_SECOND;
                holdoff_next = cfg.second_holdoff;
            end
            else
            begin
                stage_next = kda_pkg::STAGE_IDLE;
                code       = scan;
            end

            // Press and typematic repeat
            priority if (code == 8'd0)
            begin
                repeat_next = 16'd0;
            end
            else if (code == last_code_reg)
            begin
                if (repeat_reg == 16'd0)
                begin
                    repeat_next = cfg.repeat_interval;
                    key_event   = 1'b1;
                end
            end
            else
            begin
                repeat_next = cfg.initial_repeat_delay;
                key_event   = 1'b1;
            end
            last_code_next = code;
        end
    end

    assign result.key_code  = code;
    assign result.key_event = key_event;

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg     <= kda_pkg::STAGE_IDLE;
            prev_scan_reg <= 8'd0;
            last_code_reg <= 8'd0;
            holdoff_reg   <= 8'd0;
            repeat_reg    <= 16'd0;
        end
        else if (step)
        begin
            stage_reg     <= stage_next;
            prev_scan_reg <= prev_scan_next;
            last_code_reg <= last_code_next;
            holdoff_reg   <= holdoff_next;
            repeat_reg    <= repeat_next;
        end
    end

    // A running repeat timer always belongs to a held key
    `KDA_ASSERT_IMPL(a_repeat_needs_key, clk, rst_n, repeat_reg != 16'd0, last_code_reg != 8'd0)
    // Ticks leave debounce history alone
    `KDA_ASSERT_NEXT(a_tick_keeps_scan, clk, rst_n, step && item.mode == kda_pkg::MODE_TICK, $stable(stage_reg) && $stable(prev_scan_reg) && $stable(last_code_reg))
    // Polls during hold-off do not sample the pins
    `KDA_ASSERT_NEXT(a_holdoff_blocks, clk, rst_n, step && item.mode == kda_pkg::MODE_POLL && holdoff_reg != 8'd0, $stable(stage_reg) && $stable(prev_scan_reg) && last_code_reg == 8'd0)

endmodule

[hw/rtl/keypad_debounce_autorepeat.sv]
// Keypad debouncer with typematic auto-repeat. Each request is a timer tick
// (mode 0) or a keypad poll (mode 1); a tick counts down the hold-off and
// repeat timers and returns nothing, a poll returns one result with the
// debounced scan code (0 while none or still settling) and a flag set on a
// new press or an auto-repeat. One request is taken per cycle while no poll
// is blocked: it lands in an input register, is processed in a single pass,
// and its result sits in an output register, so a poll's result passes
// through both registers; only a result stalled at the output holds back
// the next poll. Timing registers are on the APB port at 0x0, 0x4, 0x8, 0xC
// and are to be written while no request is in flight.
module keypad_debounce_autorepeat (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               item_valid,
    output logic               item_ready,
    input  kda_pkg::in_item_t  item,
    output logic               result_valid,
    input  logic               result_ready,
    output kda_pkg::out_item_t result
);

`include "keypad_debounce_autorepeat_macros.svh"

    kda_pkg::cfg_t      cfg_reg;
    kda_pkg::reg_idx_t  reg_idx;
    logic               cfg_write;

    logic               in_valid_reg;
    kda_pkg::in_item_t  in_item_reg;
    logic               out_valid_reg;
    kda_pkg::out_item_t out_item_reg;

    kda_pkg::out_item_t core_result;
    logic               out_free;
    logic               advance;
    logic               load_result;

    // Configuration port
    assign pready    = 1'b1;
    assign reg_idx   = kda_pkg::reg_idx_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.first_holdoff        <= kda_pkg::FIRST_HOLDOFF_RST;
            cfg_reg.second_holdoff       <= kda_pkg::SECOND_HOLDOFF_RST;
            cfg_reg.initial_repeat_delay <= kda_pkg::INITIAL_DELAY_RST;
            cfg_reg.repeat_interval      <= kda_pkg::REPEAT_INTERVAL_RST;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                kda_pkg::REG_FIRST_HOLDOFF:   cfg_reg.first_holdoff <= pwdata[7:0];
                kda_pkg::REG_SECOND_HOLDOFF:  cfg_reg.second_holdoff <= pwdata[7:0];
                kda_pkg::REG_INITIAL_DELAY:   cfg_reg.initial_repeat_delay <= pwdata[15:0];
                kda_pkg::REG_REPEAT_INTERVAL: cfg_reg.repeat_interval <= pwdata[15:0];
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        unique case (reg_idx)
            kda_pkg::REG_FIRST_HOLDOFF:   prdata = {24'd0, cfg_reg.first_holdoff};
            kda_pkg::REG_SECOND_HOLDOFF:  prdata = {24'd0, cfg_reg.second_holdoff};
            kda_pkg::REG_INITIAL_DELAY:   prdata = {16'd0, cfg_reg.initial_repeat_delay};
            kda_pkg::REG_REPEAT_INTERVAL: prdata = {16'd0, cfg_reg.repeat_interval};
        endcase
    end

    // Flow control: ticks never wait on the output side
    assign out_free    = !out_valid_reg || result_ready;
    assign advance     = in_valid_reg && (in_item_reg.mode == kda_pkg::MODE_TICK || out_free);
    assign load_result = advance && in_item_reg.mode == kda_pkg::MODE_POLL;
    assign item_ready  = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (item_ready)
            in_valid_reg <= item_valid;
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
            in_item_reg <= item;
    end

    kda_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (in_item_reg),
        .cfg    (cfg_reg),
        .result (core_result)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= load_result;
    end

    always_ff @(posedge clk)
    begin
        if (load_result)
            out_item_reg <= core_result;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

    // An event always carries a key
    `KDA_ASSERT_IMPL(a_event_has_code, clk, rst_n,
        out_valid_reg && out_item_reg.key_event,
        out_item_reg.key_code != 8'd0)
    // A tick never produces a result
    `KDA_ASSERT_NEXT(a_tick_no_result, clk, rst_n,
        advance && in_item_reg.mode == kda_pkg::MODE_TICK,
        out_valid_reg == $past(out_valid_reg && !result_ready))
    // A blocked poll holds in the input register
    `KDA_ASSERT_NEXT(a_stall_holds, clk, rst_n,
        in_valid_reg && !advance,
        in_valid_reg && $stable(in_item_reg))

endmodule

[verif/keypad_debounce_autorepeat_tb.sv]
module keypad_debounce_autorepeat_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Directed script row: a request (repeated reps times) or a register write
    typedef enum logic {
        ROW_REQ,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        kda_pkg::in_item_t  rq;
        logic [8:0]         reps;
        logic               typed;
        kda_pkg::out_item_t want;
        kda_pkg::reg_idx_t  idx;
        logic [31:0]        val;
    } step_row_t;

    localparam int RAND_PHASES    = 8;
    localparam int PHASE_REQUESTS = 132;
    localparam int DRAIN_CYCLES   = 4;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [3:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               item_valid = 1'b0;
    logic               item_ready;
    kda_pkg::in_item_t  item = '0;
    logic               result_valid;
    logic               result_ready = 1'b1;
    kda_pkg::out_item_t result;

    keypad_debounce_autorepeat dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always #1 clk = ~clk;

    // Shadow of the timing registers
    logic [7:0]  cfg_first    = kda_pkg::FIRST_HOLDOFF_RST;
    logic [7:0]  cfg_second   = kda_pkg::SECOND_HOLDOFF_RST;
    logic [15:0] cfg_delay    = kda_pkg::INITIAL_DELAY_RST;
    logic [15:0] cfg_interval = kda_pkg::REPEAT_INTERVAL_RST;

    // Shadow of the debounce and repeat state
    kda_pkg::scan_stage_t stage      = kda_pkg::STAGE_IDLE;
    logic [7:0]           prev_scan  = '0;
    logic [7:0]           last_code  = '0;
    logic [7:0]           hold_cnt   = '0;
    logic [15:0]          repeat_cnt = '0;

    kda_pkg::out_item_t key_results[$];
    kda_pkg::out_item_t head_result;
    int                 fails = 0;
    int                 stall = 0;
    bit                 no_gaps = 1'b0;
    logic [3:0]         held_rows = 4'hF;
    logic [3:0]         held_cols = 4'hF;
    step_row_t          script[$];

    // Advance the key state by one request; returns 1 when a result is due
    function automatic bit key_step(input kda_pkg::in_item_t rq,
                                    output kda_pkg::out_item_t res);
        logic [7:0] scan;
        logic [7:0] code;
        res = '0;
        if (rq.mode == kda_pkg::MODE_TICK) begin
            if (hold_cnt != 0) hold_cnt = hold_cnt - 8'd1;
            if (repeat_cnt != 0) repeat_cnt = repeat_cnt - 16'd1;
            return 1'b0;
        end
        scan = {~rq.row_pins, ~rq.col_pins};
        code = '0;
        // three-stage debounce, skipped while the hold-off runs
        if (hold_cnt == 0) begin
            if (scan != prev_scan) begin
                stage     = kda_pkg::STAGE_FIRST;
                hold_cnt  = cfg_first;
                prev_scan = scan;
            end else if (stage == kda_pkg::STAGE_FIRST) begin
                stage     = kda_pkg::STAGE_SECOND;
                hold_cnt  = cfg_second;
                prev_scan = scan;
            end else begin
                stage = kda_pkg::STAGE_IDLE;
                code  = scan;
            end
        end
        // press / typematic repeat
        if (code == 0) begin
            repeat_cnt = '0;
        end else if (code == last_code) begin
            if (repeat_cnt == 0) begin
                repeat_cnt    = cfg_interval;
                res.key_event = 1'b1;
            end
        end else begin
            repeat_cnt    = cfg_delay;
            res.key_event = 1'b1;
        end
        last_code    = code;
        res.key_code = code;
        return 1'b1;
    endfunction

    function automatic step_row_t req_row(input logic mode, input logic [3:0] rows,
                                          input logic [3:0] cols, input int reps);
        step_row_t r;
        r      = '0;
        r.kind = ROW_REQ;
        r.rq   = '{mode, rows, cols};
        r.reps = 9'(reps);
        return r;
    endfunction

    function automatic step_row_t checked_row(input logic [3:0] rows, input logic [3:0] cols,
                                              input logic [7:0] code, input logic ev);
        step_row_t r;
        r       = req_row(kda_pkg::MODE_POLL, rows, cols, 1);
        r.typed = 1'b1;
        r.want  = '{code, ev};
        return r;
    endfunction

    function automatic step_row_t reg_row(input kda_pkg::reg_idx_t idx,
                                          input logic [31:0] val);
        step_row_t r;
        r      = '0;
        r.kind = ROW_CFG;
        r.idx  = idx;
        r.val  = val;
        return r;
    endfunction

    // Random request: mostly a held key polled between ticks, some noise
    function automatic kda_pkg::in_item_t next_request();
        kda_pkg::in_item_t rq;
        int                r;
        int                k;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            rq.mode     = 1'($urandom_range(0, 1));
            rq.row_pins = 4'($urandom);
            rq.col_pins = 4'($urandom);
            return rq;
        end
        if (r < 16) begin
            k = $urandom_range(0, 9);
            if (k < 6) begin
                held_rows = ~(4'b0001 << $urandom_range(0, 3));
                held_cols = ~(4'b0001 << $urandom_range(0, 3));
            end else if (k < 8) begin
                held_rows = 4'hF;
                held_cols = 4'hF;
            end else begin
                held_rows = 4'($urandom);
                held_cols = 4'($urandom);
            end
        end
        rq.mode     = ($urandom_range(0, 9) < 4) ? kda_pkg::MODE_TICK : kda_pkg::MODE_POLL;
        rq.row_pins = held_rows;
        rq.col_pins = held_cols;
        return rq;
    endfunction

    // Send one request; valid stays high until accepted
    task automatic issue(input kda_pkg::in_item_t rq, input bit typed,
                         input kda_pkg::out_item_t want);
        int                 gap;
        bit                 due;
        kda_pkg::out_item_t got;
        gap = no_gaps ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item       <= rq;
        item_valid <= 1'b1;
        @(posedge clk);
        while (!item_ready) @(posedge clk);
        due = key_step(rq, got);
        if (due) key_results.push_back(typed ? want : got);
    endtask

    // Stop sending, wait for every result, then let in-flight ticks settle
    task automatic drain();
        item_valid <= 1'b0;
        while (key_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // APB write followed by a readback
    task automatic write_reg(input kda_pkg::reg_idx_t idx, input logic [31:0] val);
        logic [31:0] masked;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (idx)
            kda_pkg::REG_FIRST_HOLDOFF:   cfg_first    = val[7:0];
            kda_pkg::REG_SECOND_HOLDOFF:  cfg_second   = val[7:0];
            kda_pkg::REG_INITIAL_DELAY:   cfg_delay    = val[15:0];
            kda_pkg::REG_REPEAT_INTERVAL: cfg_interval = val[15:0];
            default: ;
        endcase
        masked = (idx == kda_pkg::REG_FIRST_HOLDOFF || idx == kda_pkg::REG_SECOND_HOLDOFF) ?
                 {24'd0, val[7:0]} : {16'd0, val[15:0]};
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== masked) begin
            $error("prdata mismatch: expected %0h, actual %0h", masked, prdata);
            fails++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        // leave the bus idle before the next transfer
        @(posedge clk);
    endtask

    // Result side: random stalls, compare with the oldest expected result
    always @(posedge clk) begin
        if (rst_n) begin
            if (result_valid && result_ready) begin
                if (key_results.size() == 0) begin
                    $error("unexpected result: key_code %0h, key_event %0b",
                           result.key_code, result.key_event);
                    fails++;
                end else begin
                    head_result = key_results.pop_front();
                    if (result.key_code !== head_result.key_code) begin
                        $error("key_code mismatch: expected %0h, actual %0h",
                               head_result.key_code, result.key_code);
                        fails++;
                    end
                    if (result.key_event !== head_result.key_event) begin
                        $error("key_event mismatch: expected %0b, actual %0b",
                               head_result.key_event, result.key_event);
                        fails++;
                    end
                end
                stall = no_gaps ? 0 : $urandom_range(0, 3);
                if (stall != 0) result_ready <= 1'b0;
            end else if (!result_ready) begin
                if (stall > 1) stall--;
                else result_ready <= 1'b1;
            end
        end
    end

    initial begin
        // directed: reset state, hold-off running, zero and full-scale registers
        script.push_back(checked_row(4'hF, 4'hF, 8'h00, 1'b0));
        script.push_back(checked_row(4'h0, 4'h0, 8'h00, 1'b0));
        script.push_back(checked_row(4'h0, 4'h0, 8'h00, 1'b0));
        script.push_back(req_row(kda_pkg::MODE_TICK, 4'h0, 4'hF, 10));
        script.push_back(reg_row(kda_pkg::REG_FIRST_HOLDOFF, 32'd0));
        script.push_back(reg_row(kda_pkg::REG_SECOND_HOLDOFF, 32'd0));
        script.push_back(reg_row(kda_pkg::REG_INITIAL_DELAY, 32'd0));
        script.push_back(reg_row(kda_pkg::REG_REPEAT_INTERVAL, 32'd65535));
        script.push_back(req_row(kda_pkg::MODE_POLL, 4'h0, 4'h0, 4));
        script.push_back(req_row(kda_pkg::MODE_TICK, 4'hA, 4'h5, 1));
        script.push_back(req_row(kda_pkg::MODE_POLL, 4'hF, 4'hF, 1));
        script.push_back(reg_row(kda_pkg::REG_INITIAL_DELAY, 32'd65535));
        script.push_back(reg_row(kda_pkg::REG_REPEAT_INTERVAL, 32'd0));
        script.push_back(reg_row(kda_pkg::REG_FIRST_HOLDOFF, 32'd1));
        script.push_back(reg_row(kda_pkg::REG_SECOND_HOLDOFF, 32'd2));
        script.push_back(req_row(kda_pkg::MODE_POLL, 4'hE, 4'hD, 2));
        script.push_back(req_row(kda_pkg::MODE_TICK, 4'hF, 4'hF, 1));
        script.push_back(req_row(kda_pkg::MODE_POLL, 4'hE, 4'hD, 1));
        script.push_back(req_row(kda_pkg::MODE_TICK, 4'h5, 4'hA, 2));
        script.push_back(req_row(kda_pkg::MODE_POLL, 4'hE, 4'hD, 2));
        script.push_back(req_row(kda_pkg::MODE_POLL, 4'h7, 4'hB, 1));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i]) begin
            if (script[i].kind == ROW_CFG) begin
                drain();
                write_reg(script[i].idx, script[i].val);
            end else begin
                repeat (script[i].reps) issue(script[i].rq, script[i].typed, script[i].want);
            end
        end

        // random phases, each under its own register setting
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            drain();
            case (ph)
                0: begin
                    write_reg(kda_pkg::REG_FIRST_HOLDOFF, 32'd0);
                    write_reg(kda_pkg::REG_SECOND_HOLDOFF, 32'd0);
                    write_reg(kda_pkg::REG_INITIAL_DELAY, 32'd0);
                    write_reg(kda_pkg::REG_REPEAT_INTERVAL, 32'd0);
                end
                RAND_PHASES - 2: begin
                    write_reg(kda_pkg::REG_FIRST_HOLDOFF, 32'(kda_pkg::FIRST_HOLDOFF_RST));
                    write_reg(kda_pkg::REG_SECOND_HOLDOFF, 32'(kda_pkg::SECOND_HOLDOFF_RST));
                    write_reg(kda_pkg::REG_INITIAL_DELAY, 32'(kda_pkg::INITIAL_DELAY_RST));
                    write_reg(kda_pkg::REG_REPEAT_INTERVAL, 32'(kda_pkg::REPEAT_INTERVAL_RST));
                end
                RAND_PHASES - 1: begin
                    write_reg(kda_pkg::REG_FIRST_HOLDOFF, 32'hFFFF_FFFF);
                    write_reg(kda_pkg::REG_SECOND_HOLDOFF, 32'hFFFF_FFFF);
                    write_reg(kda_pkg::REG_INITIAL_DELAY, 32'hFFFF_FFFF);
                    write_reg(kda_pkg::REG_REPEAT_INTERVAL, 32'hFFFF_FFFF);
                end
                default: begin
                    write_reg(kda_pkg::REG_FIRST_HOLDOFF, $urandom_range(0, 4));
                    write_reg(kda_pkg::REG_SECOND_HOLDOFF, $urandom_range(0, 3));
                    write_reg(kda_pkg::REG_INITIAL_DELAY, $urandom_range(0, 15));
                    write_reg(kda_pkg::REG_REPEAT_INTERVAL, $urandom_range(0, 6));
                end
            endcase
            for (int n = 0; n < PHASE_REQUESTS; n++) begin
                if (n % 33 == 0) no_gaps = ($urandom_range(0, 3) == 0);
                issue(next_request(), 1'b0, '0);
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fails == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog
    initial begin
        #200000;
        $display("tb: failure");
        $finish;
    end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/kda_pkg.sv
hw/rtl/kda_core.sv
hw/rtl/keypad_debounce_autorepeat.sv
verif/keypad_debounce_autorepeat_tb.sv
